// ===== rtl/core/stip_pkg.sv =====
`default_nettype none

package stip_pkg;

    // Field widths
    localparam int CharW    = 8;
    localparam int RadixW   = 6;
    localparam int ValueW   = 64;
    localparam int OffsetW  = 12;
    localparam int OutDataW = 80;

    // Largest offset the result field can carry
    localparam int OffsetMax = (1 << OffsetW) - 1;

    // Token queue between front and back
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    // Character codes
    localparam logic [CharW-1:0] ChZero  = 8'h30;
    localparam logic [CharW-1:0] ChNine  = 8'h39;
    localparam logic [CharW-1:0] ChLowA  = 8'h61;
    localparam logic [CharW-1:0] ChLowZ  = 8'h7A;
    localparam logic [CharW-1:0] ChUpA   = 8'h41;
    localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
    localparam logic [CharW-1:0] ChLowX  = 8'h78;
    localparam logic [CharW-1:0] ChUpX   = 8'h58;
    localparam logic [CharW-1:0] ChPlus  = 8'h2B;
    localparam logic [CharW-1:0] ChMinus = 8'h2D;
    localparam logic [CharW-1:0] ChSpace = 8'h20;
    localparam logic [CharW-1:0] ChTab   = 8'h09;
    localparam logic [CharW-1:0] ChLf    = 8'h0A;
    localparam logic [CharW-1:0] ChVt    = 8'h0B;
    localparam logic [CharW-1:0] ChFf    = 8'h0C;
    localparam logic [CharW-1:0] ChCr    = 8'h0D;
    localparam logic [CharW-1:0] LetterBias = 8'd10;

    // Number bases
    localparam logic [RadixW-1:0] RadixAuto = 6'd0;
    localparam logic [RadixW-1:0] Base8     = 6'd8;
    localparam logic [RadixW-1:0] Base10    = 6'd10;
    localparam logic [RadixW-1:0] Base16    = 6'd16;

    // Parse phase
    typedef enum logic [2:0] {
        PH_SPACE,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // Classified byte
    typedef struct packed {
        logic              is_last;
        logic              is_space;
        logic              is_sign;
        logic              is_minus;
        logic              is_zero;
        logic              is_x;
        logic              is_digit;
        logic [RadixW-1:0] digit;
    } token_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/stip_front.sv =====
`default_nettype none

module stip_front (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [stip_pkg::CharW-1:0]    s_tdata,   // [7:0] char_in
    input  wire logic                          s_tlast,   // is_last
    input  wire stip_pkg::qstat_t              q_stat,
    output logic                               push,
    output stip_pkg::token_t                   tok
);

    // Take a byte whenever the queue has room
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    // Classify the byte
    always_comb begin
        tok          = '0;
        tok.is_last  = s_tlast;
        tok.is_space = s_tdata inside {stip_pkg::ChSpace, stip_pkg::ChTab, stip_pkg::ChLf,
                                       stip_pkg::ChVt, stip_pkg::ChFf, stip_pkg::ChCr};
        tok.is_sign  = (s_tdata == stip_pkg::ChPlus) || (s_tdata == stip_pkg::ChMinus);
        tok.is_minus = (s_tdata == stip_pkg::ChMinus);
        tok.is_zero  = (s_tdata == stip_pkg::ChZero);
        tok.is_x     = (s_tdata == stip_pkg::ChLowX) || (s_tdata == stip_pkg::ChUpX);
        if (s_tdata inside {[stip_pkg::ChZero:stip_pkg::ChNine]}) begin
            tok.is_digit = 1'b1;
            tok.digit    = stip_pkg::RadixW'(s_tdata - stip_pkg::ChZero);
        end else if (s_tdata inside {[stip_pkg::ChLowA:stip_pkg::ChLowZ]}) begin
            tok.is_digit = 1'b1;
            tok.digit    = stip_pkg::RadixW'(s_tdata - stip_pkg::ChLowA + stip_pkg::LetterBias);
        end else if (s_tdata inside {[stip_pkg::ChUpA:stip_pkg::ChUpZ]}) begin
            tok.is_digit = 1'b1;
            tok.digit    = stip_pkg::RadixW'(s_tdata - stip_pkg::ChUpA + stip_pkg::LetterBias);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stip_fifo.sv =====
`default_nettype none

module stip_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire stip_pkg::token_t  wr_tok,
    input  wire logic              pop,
    output stip_pkg::token_t       rd_tok,
    output stip_pkg::qstat_t       q_stat
);

    stip_pkg::token_t                 mem_reg [stip_pkg::QueueDepth];
    logic [stip_pkg::QPtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [stip_pkg::QPtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [stip_pkg::QCntW-1:0]       count_reg, count_next;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_tok;
        end
    end

    assign rd_tok       = mem_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == stip_pkg::QCntW'(stip_pkg::QueueDepth));

endmodule

`default_nettype wire

// ===== rtl/core/stip_back.sv =====
`default_nettype none

module stip_back #(
    parameter int MAX_LEN = 4095
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [stip_pkg::RadixW-1:0]    cfg_wr_data,
    input  wire stip_pkg::qstat_t               q_stat,
    input  wire stip_pkg::token_t               q_tok,
    output logic                                pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [stip_pkg::OutDataW-1:0]       m_tdata
);

    localparam logic [stip_pkg::OffsetW-1:0] PosLimit = stip_pkg::OffsetW'(
        (MAX_LEN < stip_pkg::OffsetMax) ? MAX_LEN : stip_pkg::OffsetMax);

    logic [stip_pkg::RadixW-1:0]   radix_reg;
    stip_pkg::phase_t              phase_reg, phase_next;
    logic                          neg_reg, neg_next;
    logic [stip_pkg::RadixW-1:0]   base_reg, base_next;
    logic [stip_pkg::ValueW-1:0]   acc_reg, acc_next;
    logic [stip_pkg::OffsetW-1:0]  pos_reg, pos_next;
    logic                          any_reg, any_next;
    logic                          out_valid_reg, out_valid_next;
    logic [stip_pkg::OutDataW-1:0] out_data_reg, out_data_next;

    logic                          auto_pref, sp_keep, sp_sign, in_pref, to_zero;
    logic                          x_hit, zero_digit, dig_step, take, adv, out_load;
    logic [stip_pkg::RadixW-1:0]   base_sel;
    logic [stip_pkg::ValueW-1:0]   mul, addend, acc_step, acc_upd;
    logic [stip_pkg::OffsetW-1:0]  pos_upd;
    logic                          any_upd;

    // Pop when the token can be finished: a last byte needs a free result slot
    assign pop      = !q_stat.empty && (!q_tok.is_last || !out_valid_reg || m_tready);
    assign out_load = pop && q_tok.is_last;

    // Decode what this byte does in the current phase
    always_comb begin
        auto_pref  = (radix_reg == stip_pkg::RadixAuto) || (radix_reg == stip_pkg::Base16);
        sp_keep    = (phase_reg == stip_pkg::PH_SPACE) && q_tok.is_space;
        sp_sign    = (phase_reg == stip_pkg::PH_SPACE) && !q_tok.is_space && q_tok.is_sign;
        in_pref    = ((phase_reg == stip_pkg::PH_SPACE) && !q_tok.is_space && !q_tok.is_sign)
                     || (phase_reg == stip_pkg::PH_PREFIX);
        to_zero    = in_pref && q_tok.is_zero && auto_pref;
        x_hit      = (phase_reg == stip_pkg::PH_ZERO) && q_tok.is_x;
        zero_digit = (phase_reg == stip_pkg::PH_ZERO) && !q_tok.is_x;
        dig_step   = (in_pref && !to_zero) || zero_digit || (phase_reg == stip_pkg::PH_DIGITS);
        if (in_pref) begin
            base_sel = (radix_reg == stip_pkg::RadixAuto) ? stip_pkg::Base10 : radix_reg;
        end else if (phase_reg == stip_pkg::PH_ZERO) begin
            base_sel = (radix_reg == stip_pkg::RadixAuto) ? stip_pkg::Base8 : stip_pkg::Base16;
        end else begin
            base_sel = base_reg;
        end
        take = dig_step && q_tok.is_digit && (q_tok.digit < base_sel);
        adv  = sp_keep || sp_sign || to_zero || x_hit || take;
    end

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (pop) begin
            if (q_tok.is_last) begin
                phase_next = stip_pkg::PH_SPACE;
            end else if (sp_keep) begin
                phase_next = stip_pkg::PH_SPACE;
            end else if (sp_sign) begin
                phase_next = stip_pkg::PH_PREFIX;
            end else if (to_zero) begin
                phase_next = stip_pkg::PH_ZERO;
            end else if (x_hit) begin
                phase_next = stip_pkg::PH_DIGITS;
            end else if (dig_step) begin
                phase_next = take ? stip_pkg::PH_DIGITS : stip_pkg::PH_DONE;
            end
        end
    end

    // Datapath: the value is kept already signed, so a minus sign subtracts each digit
    always_comb begin
        mul      = acc_reg * stip_pkg::ValueW'(base_sel);
        addend   = neg_reg ? (stip_pkg::ValueW'(0) - stip_pkg::ValueW'(q_tok.digit))
                           : stip_pkg::ValueW'(q_tok.digit);
        acc_step = mul + addend;
        acc_upd  = take ? acc_step : acc_reg;
        pos_upd  = (adv && (pos_reg < PosLimit)) ? pos_reg + 1'b1 : pos_reg;
        any_upd  = any_reg || zero_digit || take || (to_zero && q_tok.is_last);

        neg_next  = neg_reg;
        base_next = base_reg;
        acc_next  = acc_reg;
        pos_next  = pos_reg;
        any_next  = any_reg;
        if (pop) begin
            if (q_tok.is_last) begin
                neg_next  = 1'b0;
                base_next = '0;
                acc_next  = '0;
                pos_next  = '0;
                any_next  = 1'b0;
            end else begin
                if (sp_sign) begin
                    neg_next = q_tok.is_minus;
                end
                if (x_hit) begin
                    base_next = stip_pkg::Base16;
                end else if (dig_step) begin
                    base_next = base_sel;
                end
                acc_next = acc_upd;
                pos_next = pos_upd;
                any_next = any_upd;
            end
        end

        // Result register: value, offset, converted flag from the low bits up
        out_data_next = out_data_reg;
        if (out_load) begin
            out_data_next = '0;
            if (any_upd) begin
                out_data_next[stip_pkg::ValueW-1:0] = acc_upd;
                out_data_next[stip_pkg::ValueW +: stip_pkg::OffsetW] = pos_upd;
                out_data_next[stip_pkg::ValueW + stip_pkg::OffsetW] = 1'b1;
            end
        end
        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg     <= stip_pkg::RadixAuto;
            phase_reg     <= stip_pkg::PH_SPACE;
            neg_reg       <= 1'b0;
            base_reg      <= '0;
            acc_reg       <= '0;
            pos_reg       <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                radix_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            base_reg      <= base_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/string_to_integer_parser_unit.sv =====
`default_nettype none

// strtol-style integer parser. A string enters one byte per transfer on the
// s_ stream, the final byte flagged by s_tlast; one result per string leaves on
// the m_ stream with the signed 64-bit value (wrapping), the offset of the first
// unused byte (0 when nothing was converted, saturating at MAX_LEN or 4095) and
// a converted flag. cfg_wr_data sets the radix (0 = auto: 0x prefix for hex,
// leading 0 for octal, else decimal); write it only between strings. Sustained
// rate is one byte per clock unless a held result blocks a last byte. Classified
// bytes pass through a 4-entry token queue to the parser, whose 64x6 multiply-add
// handles one byte per cycle on that condition; a result is registered onto m_tdata
// when its last byte leaves the queue, and further bytes flow while a result waits.
module string_to_integer_parser_unit #(
    parameter int MAX_LEN = 4095
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [stip_pkg::RadixW-1:0]    cfg_wr_data,   // radix
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [stip_pkg::CharW-1:0]     s_tdata,       // [7:0] char_in
    input  wire logic                           s_tlast,       // is_last
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [stip_pkg::OutDataW-1:0]       m_tdata        // [63:0] value,
                                                                // [75:64] end_offset,
                                                                // [76] converted
);

    stip_pkg::token_t front_tok;
    stip_pkg::token_t q_tok;
    stip_pkg::qstat_t q_stat;
    logic             push;
    logic             pop;

    // Byte classification and input handshake
    stip_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .tok      (front_tok)
    );

    // Token queue
    stip_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_tok  (front_tok),
        .pop     (pop),
        .rd_tok  (q_tok),
        .q_stat  (q_stat)
    );

    // Parser and result register
    stip_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_stat      (q_stat),
        .q_tok       (q_tok),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTH
    // A new result only appears after a last byte left the queue
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !($past(m_tvalid) && !$past(m_tready)))
            |-> $past(pop && q_tok.is_last))
        else $error("result without a last byte");

    // A last byte is never consumed while an unaccepted result is held
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_tok.is_last) |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // Nothing converted means zero value and zero offset
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[76]) |-> (m_tdata[75:0] == 76'd0))
        else $error("unconverted result not cleared");

    // Queue never pops when empty nor pushes when full
    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && q_stat.empty) && !(push && q_stat.full))
        else $error("token queue bound violated");
`endif

endmodule

`default_nettype wire
